// ===== src/anxb_pkg.sv =====
// Shared constants, types and helper functions for the Annex B NAL scanner.
package anxb_pkg;

    localparam int POSITION_BITS = 24;
    localparam int BYTE_W        = 8;
    localparam int FIELD_W       = 24;
    localparam int TYPE_W        = 6;
    localparam int TOTAL_W       = 25;
    localparam int HISTORY_W     = 3 * BYTE_W;
    localparam int WIDE_W        = (POSITION_BITS > FIELD_W) ? POSITION_BITS : FIELD_W;

    localparam int S_TDATA_W     = BYTE_W;
    localparam int M_PAYLOAD_W   = 1 + FIELD_W + FIELD_W + TYPE_W + TOTAL_W + 1 + 1;
    localparam int M_TDATA_W     = ((M_PAYLOAD_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0]        BYTE_ZERO   = 8'h00;
    localparam logic [BYTE_W-1:0]        BYTE_ONE    = 8'h01;
    localparam logic [HISTORY_W-1:0]     HISTORY_RST = {HISTORY_W{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_MAX     = {POSITION_BITS{1'b1}};
    localparam logic [FIELD_W-1:0]       FIELD_MAX   = {FIELD_W{1'b1}};
    localparam logic [TOTAL_W-1:0]       TOTAL_MAX   = {TOTAL_W{1'b1}};
    localparam logic [TOTAL_W:0]         PREFIX_LEN  = (TOTAL_W + 1)'(4);

    // One closed NAL and/or the end of the unit, handed from the scanner to the accumulator.
    typedef struct packed {
        logic                 nal_valid;
        logic [FIELD_W-1:0]   nal_offset;
        logic [FIELD_W-1:0]   nal_size;
        logic [TYPE_W-1:0]    nal_type;
        logic                 unit_end;
        logic                 any_nal;
        logic                 pos_overflow;
    } close_t;

    function automatic logic [FIELD_W-1:0] sat_field(input logic [POSITION_BITS-1:0] v);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        if (w > WIDE_W'(FIELD_MAX)) begin
            return FIELD_MAX;
        end
        return w[FIELD_W-1:0];
    endfunction

endpackage

// ===== src/anxb_scanner.sv =====
// Start code scanner: tracks byte positions and the open NAL, registers each close event.
module anxb_scanner (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [anxb_pkg::BYTE_W-1:0]       in_byte,
    input  logic                              in_last,
    input  logic                              adv,
    output logic                              out_valid,
    output anxb_pkg::close_t                  out_rec
);
    import anxb_pkg::*;

    logic [HISTORY_W-1:0]     recent_reg, recent_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] len_reg, len_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic                     open_reg, open_next;
    logic [TYPE_W-1:0]        kind_reg, kind_next;
    logic                     any_reg, any_next;
    logic                     povf_reg, povf_next;
    logic                     valid_reg, valid_next;
    close_t                   rec_reg, rec_next;

    logic                     accept;
    logic                     in_range;
    logic                     start_code;
    logic [1:0]               back;
    logic                     sc_emit;
    logic                     last_emit;
    logic [POSITION_BITS-1:0] count;
    logic [POSITION_BITS-1:0] len_step;
    logic [POSITION_BITS-1:0] sc_size;

    assign in_ready  = !valid_reg || adv;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;

    // The length counter follows the distance from the payload start to the current byte.
    always_comb begin
        in_range   = (pos_reg != POS_MAX);
        start_code = (in_byte == BYTE_ONE) && (recent_reg[7:0] == BYTE_ZERO)
                     && (recent_reg[15:8] == BYTE_ZERO);
        back       = (recent_reg[23:16] == BYTE_ZERO) ? 2'd3 : 2'd2;
        sc_emit    = open_reg && start_code && (len_reg > POSITION_BITS'(back));
        sc_size    = len_reg - POSITION_BITS'(back);
        count      = in_range ? pos_reg + POSITION_BITS'(1) : pos_reg;
        len_step   = in_range ? len_reg + POSITION_BITS'(1) : len_reg;

        kind_next = kind_reg;
        if (open_reg && in_range && (len_reg == '0)) begin
            kind_next = in_byte[TYPE_W:1];
        end
        open_next  = open_reg;
        start_next = start_reg;
        len_next   = len_step;
        if (start_code) begin
            kind_next  = '0;
            open_next  = 1'b1;
            start_next = count;
            len_next   = '0;
        end
        recent_next = {recent_reg[HISTORY_W-BYTE_W-1:0], in_byte};
        pos_next    = count;

        // A start code on the last byte leaves an empty NAL, so only one close can be non-empty.
        last_emit = in_last && open_next && (len_next != '0);

        rec_next.nal_valid    = sc_emit || last_emit;
        rec_next.nal_offset   = rec_next.nal_valid ? sat_field(start_reg) : '0;
        rec_next.nal_size     = sc_emit ? sat_field(sc_size)
                              : (last_emit ? sat_field(len_next) : '0);
        rec_next.nal_type     = sc_emit ? kind_reg : (last_emit ? kind_next : '0);
        rec_next.unit_end     = in_last;
        any_next              = any_reg || rec_next.nal_valid;
        povf_next             = povf_reg || !in_range;
        rec_next.any_nal      = any_next;
        rec_next.pos_overflow = povf_next;

        valid_next = valid_reg;
        if (accept) begin
            valid_next = rec_next.nal_valid || in_last;
        end else if (adv) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent_reg <= HISTORY_RST;
            pos_reg    <= '0;
            len_reg    <= '0;
            start_reg  <= '0;
            open_reg   <= 1'b0;
            kind_reg   <= '0;
            any_reg    <= 1'b0;
            povf_reg   <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (accept) begin
                if (in_last) begin
                    recent_reg <= HISTORY_RST;
                    pos_reg    <= '0;
                    len_reg    <= '0;
                    start_reg  <= '0;
                    open_reg   <= 1'b0;
                    kind_reg   <= '0;
                    any_reg    <= 1'b0;
                    povf_reg   <= 1'b0;
                end else begin
                    recent_reg <= recent_next;
                    pos_reg    <= pos_next;
                    len_reg    <= len_next;
                    start_reg  <= start_next;
                    open_reg   <= open_next;
                    kind_reg   <= kind_next;
                    any_reg    <= any_next;
                    povf_reg   <= povf_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rec_reg <= rec_next;
        end
    end

endmodule

// ===== src/anxb_accum.sv =====
// Result stage: accumulates the length-prefixed total and holds the outgoing transaction.
module anxb_accum (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    input  anxb_pkg::close_t                  in_rec,
    output logic                              adv,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [anxb_pkg::M_TDATA_W-1:0]    out_data,
    output logic                              out_last
);
    import anxb_pkg::*;

    logic                 valid_reg, valid_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic                 tovf_reg, tovf_next;
    logic [TOTAL_W:0]     sum;
    logic                 load;

    logic                 nal_valid_reg;
    logic [FIELD_W-1:0]   offset_reg;
    logic [FIELD_W-1:0]   size_reg;
    logic [TYPE_W-1:0]    type_reg;
    logic                 unit_end_reg;
    logic [TOTAL_W-1:0]   ptotal_reg, ptotal_next;
    logic                 no_nal_reg, no_nal_next;
    logic                 oversize_reg, oversize_next;

    assign adv  = !valid_reg || out_ready;
    assign load = in_valid && adv;

    always_comb begin
        sum        = {1'b0, total_reg} + (TOTAL_W + 1)'(in_rec.nal_size) + PREFIX_LEN;
        total_next = total_reg;
        tovf_next  = tovf_reg;
        if (in_rec.nal_valid) begin
            if (sum > (TOTAL_W + 1)'(TOTAL_MAX)) begin
                total_next = TOTAL_MAX;
                tovf_next  = 1'b1;
            end else begin
                total_next = sum[TOTAL_W-1:0];
            end
        end
        ptotal_next   = in_rec.unit_end ? total_next : '0;
        no_nal_next   = in_rec.unit_end && !in_rec.any_nal;
        oversize_next = in_rec.unit_end && (in_rec.pos_overflow || tovf_next);
        valid_next    = adv ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            total_reg <= '0;
            tovf_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (load) begin
                // The unit's running sums start over after its last transaction.
                if (in_rec.unit_end) begin
                    total_reg <= '0;
                    tovf_reg  <= 1'b0;
                end else begin
                    total_reg <= total_next;
                    tovf_reg  <= tovf_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            nal_valid_reg <= in_rec.nal_valid;
            offset_reg    <= in_rec.nal_offset;
            size_reg      <= in_rec.nal_size;
            type_reg      <= in_rec.nal_type;
            unit_end_reg  <= in_rec.unit_end;
            ptotal_reg    <= ptotal_next;
            no_nal_reg    <= no_nal_next;
            oversize_reg  <= oversize_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_last  = unit_end_reg;
    assign out_data  = {(M_TDATA_W - M_PAYLOAD_W)'(0), oversize_reg, no_nal_reg, ptotal_reg,
                        type_reg, size_reg, offset_reg, nal_valid_reg};

endmodule

// ===== src/annexb_nal_splitter_top.sv =====
// Top level of the Annex B NAL scanner: stream ports around the scanner and result stages.
//
// The slave stream carries one byte of an Annex B access unit per transaction,
// with s_tlast on the unit's final byte. The master stream carries one
// transaction for every non-empty NAL that closes (at a start code or at the
// unit's end) and one for the unit's last byte; both can coincide in a single
// transaction. m_tlast marks the transaction caused by the unit's last byte,
// which also carries the length-prefixed total, the no-NAL flag and the
// oversize flag. Bytes before the first start code are skipped.
// Throughput is one byte per cycle unless both registers hold results and the
// receiver stalls. A result passes through the scanner's close register and
// then the result register before it appears on the master side.
// When the receiver stalls, the scanner keeps taking bytes that cause no result
// and can park one result in its close register; it stops taking bytes only
// when both registers hold results. Reset (aresetn low, synchronous) empties
// both registers and returns the scanner to the start of a unit.
module annexb_nal_splitter_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [anxb_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] stream_byte
    input  logic                               s_tlast,   // unit_last
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] nal_valid, [24:1] nal_offset, [48:25] nal_size, [54:49] nal_type,
    // [79:55] prefixed_total, [80] no_nal_error, [81] oversize, [87:82] zero
    output logic [anxb_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tlast    // unit_end
);
    import anxb_pkg::*;

    logic   adv;
    logic   close_valid;
    close_t close_rec;

    anxb_scanner u_scanner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata[BYTE_W-1:0]),
        .in_last   (s_tlast),
        .adv       (adv),
        .out_valid (close_valid),
        .out_rec   (close_rec)
    );

    anxb_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (close_valid),
        .in_rec    (close_rec),
        .adv       (adv),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
